### rtl/sodcc_pkg.sv
// Package for the seconds-of-day calendar clock: time constants, mode codes,
// item structs and the month-length table. No dependencies.
package sodcc_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned MinsPerHour = 60;
  localparam int unsigned MonthsPerYear = 12;

  localparam int unsigned SodW = 17;

  localparam logic [SodW-1:0] DayLength  = SodW'(SecsPerDay);
  localparam logic [SodW-1:0] LastSecond = SodW'(SecsPerDay - 1);

  localparam logic [4:0] ResetDay   = 5'd1;
  localparam logic [3:0] ResetMonth = 4'd1;
  localparam logic [7:0] ResetYear  = 8'd19;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_SET_TIME = 2'd1,
    MODE_SET_DATE = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t           mode;
    logic [4:0]      set_hour;
    logic [5:0]      set_minute;
    logic [5:0]      set_second;
    logic [4:0]      set_day;
    logic [3:0]      set_month;
    logic [7:0]      set_year;
    logic [SodW-1:0] mark_time;
    logic [SodW-1:0] wait_length;
  } sodcc_req_t;

  typedef struct packed {
    logic [4:0]      hour;
    logic [5:0]      minute;
    logic [5:0]      second;
    logic [4:0]      day;
    logic [3:0]      month;
    logic [7:0]      year;
    logic [SodW-1:0] elapsed;
    logic            passed;
    logic            rejected;
  } sodcc_rsp_t;

  // Fixed month lengths, no leap years; codes outside 1..12 read as 31.
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] days;
    case (m) inside
      MonthFeb:                             days = 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: days = 5'd30;
      default:                              days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

### rtl/sodcc_if.sv
// Valid/ready channel interfaces for the calendar clock request and response.
// Depends on sodcc_pkg for the payload structs.
interface sodcc_req_if import sodcc_pkg::*; ();
  logic       valid;
  logic       ready;
  sodcc_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sodcc_rsp_if import sodcc_pkg::*; ();
  logic       valid;
  logic       ready;
  sodcc_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/seconds_of_day_calendar_clock_unit.sv
// Top level of the seconds-of-day calendar clock.
// Depends on sodcc_pkg and the channel interfaces in sodcc_if.sv.
//
// Usage:
//   req carries one item per handshake: a one-second tick, a set time, a set
//   date or an elapsed-time query. rsp returns exactly one item per request
//   with the time (hour, minute, second) and date as they stand after that
//   request, plus elapsed/passed for a query and rejected for a bad set.
//   An accepted item passes through the input register (range checks,
//   set-time seconds product, mark folding) and then the result register,
//   which loads as the clock state updates; rsp valid rises when the result
//   register loads. Throughput is one item per cycle while rsp.ready is high;
//   the state update is a single short step, so an item in the input
//   register always sees the state left by the item just ahead of it.
//   Reset (rst, synchronous) clears the pipeline and sets the clock to
//   00:00:00 on day 1, month 1, year 19.
//   When the receiver holds rsp.ready low, the result register holds its
//   item, the input register can still take one more item, and then
//   req.ready drops until the result is taken.
module seconds_of_day_calendar_clock_unit import sodcc_pkg::*; (
  input logic         clk,
  input logic         rst,
  sodcc_req_if.sink   req,
  sodcc_rsp_if.source rsp
);

  // Input register stage
  logic            s1_valid;
  mode_t           s1_mode;
  logic            s1_time_ok;
  logic            s1_date_ok;
  logic [SodW-1:0] s1_set_sod;
  logic [4:0]      s1_set_hour;
  logic [5:0]      s1_set_minute;
  logic [5:0]      s1_set_second;
  logic [4:0]      s1_set_day;
  logic [3:0]      s1_set_month;
  logic [7:0]      s1_set_year;
  logic [SodW-1:0] s1_mark;
  logic [SodW-1:0] s1_wait;

  // Clock state
  logic [SodW-1:0] sod;
  logic [4:0]      hour;
  logic [5:0]      minute;
  logic [5:0]      second;
  logic [4:0]      day;
  logic [3:0]      month;
  logic [7:0]      year;

  logic [SodW-1:0] sod_next;
  logic [4:0]      hour_next;
  logic [5:0]      minute_next;
  logic [5:0]      second_next;
  logic [4:0]      day_next;
  logic [3:0]      month_next;
  logic [7:0]      year_next;

  // Result register
  logic       out_valid;
  sodcc_rsp_t out_data;

  logic       req_fire;
  logic       out_load;
  logic       in_time_ok;
  logic       in_date_ok;
  logic [SodW-1:0] in_set_sod;
  logic [SodW-1:0] in_mark;

  logic [SodW-1:0] elapsed;
  logic            passed;
  logic            rejected;

  // Result register takes the stage-1 item when empty or being drained.
  assign out_load  = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || out_load;
  assign req_fire  = req.valid && req.ready;

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Range checks and set-time seconds, done ahead of the state update.
  assign in_time_ok = (req.data.set_hour < 5'(HoursPerDay)) &&
                      (req.data.set_minute < 6'(MinsPerHour)) &&
                      (req.data.set_second < 6'(SecsPerMin));
  assign in_date_ok = (req.data.set_month >= MonthJan) &&
                      (req.data.set_month <= 4'(MonthsPerYear)) &&
                      (req.data.set_day != 5'd0) &&
                      (req.data.set_day <= month_days(req.data.set_month));
  assign in_set_sod = SodW'(req.data.set_hour) * SodW'(SecsPerHour) +
                      SodW'(req.data.set_minute) * SodW'(SecsPerMin) +
                      SodW'(req.data.set_second);
  // Fold a mark at or past one day back into range.
  assign in_mark = (req.data.mark_time >= DayLength) ? req.data.mark_time - DayLength
                                                     : req.data.mark_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req_fire) begin
      s1_mode       <= req.data.mode;
      s1_time_ok    <= in_time_ok;
      s1_date_ok    <= in_date_ok;
      s1_set_sod    <= in_set_sod;
      s1_set_hour   <= req.data.set_hour;
      s1_set_minute <= req.data.set_minute;
      s1_set_second <= req.data.set_second;
      s1_set_day    <= req.data.set_day;
      s1_set_month  <= req.data.set_month;
      s1_set_year   <= req.data.set_year;
      s1_mark       <= in_mark;
      s1_wait       <= req.data.wait_length;
    end
  end

  // State update for the item in the input register. The h/m/s counters
  // track sod so the result never needs a divide by 3600 or 60.
  always_comb begin
    sod_next    = sod;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    day_next    = day;
    month_next  = month;
    year_next   = year;
    elapsed     = '0;
    passed      = 1'b0;
    rejected    = 1'b0;
    unique case (s1_mode)
      MODE_TICK: begin
        if (sod == LastSecond) begin
          // Midnight: clear the time and advance the date.
          sod_next    = '0;
          hour_next   = '0;
          minute_next = '0;
          second_next = '0;
          if (day >= month_days(month)) begin
            day_next = ResetDay;
            if (month >= MonthDec || month < MonthJan) begin
              month_next = MonthJan;
              year_next  = year + 8'd1;
            end else begin
              month_next = month + 4'd1;
            end
          end else begin
            day_next = day + 5'd1;
          end
        end else begin
          sod_next = sod + SodW'(1);
          if (second == 6'(SecsPerMin - 1)) begin
            second_next = '0;
            if (minute == 6'(MinsPerHour - 1)) begin
              minute_next = '0;
              hour_next   = hour + 5'd1;
            end else begin
              minute_next = minute + 6'd1;
            end
          end else begin
            second_next = second + 6'd1;
          end
        end
      end
      MODE_SET_TIME: begin
        if (s1_time_ok) begin
          sod_next    = s1_set_sod;
          hour_next   = s1_set_hour;
          minute_next = s1_set_minute;
          second_next = s1_set_second;
        end else begin
          rejected = 1'b1;
        end
      end
      MODE_SET_DATE: begin
        if (s1_date_ok) begin
          day_next   = s1_set_day;
          month_next = s1_set_month;
          year_next  = s1_set_year;
        end else begin
          rejected = 1'b1;
        end
      end
      MODE_QUERY: begin
        // Add a day when the mark lies after the current time.
        if (sod >= s1_mark) begin
          elapsed = sod - s1_mark;
        end else begin
          elapsed = SodW'((SodW+1)'(sod) + (SodW+1)'(DayLength) - (SodW+1)'(s1_mark));
        end
        passed = (elapsed >= s1_wait);
      end
      default: begin
        rejected = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sod    <= '0;
      hour   <= '0;
      minute <= '0;
      second <= '0;
      day    <= ResetDay;
      month  <= ResetMonth;
      year   <= ResetYear;
    end else if (out_load) begin
      sod    <= sod_next;
      hour   <= hour_next;
      minute <= minute_next;
      second <= second_next;
      day    <= day_next;
      month  <= month_next;
      year   <= year_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data.hour     <= hour_next;
      out_data.minute   <= minute_next;
      out_data.second   <= second_next;
      out_data.day      <= day_next;
      out_data.month    <= month_next;
      out_data.year     <= year_next;
      out_data.elapsed  <= elapsed;
      out_data.passed   <= passed;
      out_data.rejected <= rejected;
    end
  end

endmodule

### rtl/sodcc_checker.sv
// Port-level checker for the calendar clock, bound to the top level.
// Depends on sodcc_pkg for the time constants.
module sodcc_checker import sodcc_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input logic [4:0]      hour,
  input logic [5:0]      minute,
  input logic [5:0]      second,
  input logic [3:0]      month,
  input logic [SodW-1:0] elapsed,
  input logic            passed,
  input logic            rejected
);

  // Request side only backs up behind a stalled result.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (rsp_valid && !rsp_ready))
    else $error("req stalled without a stalled response");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(hour) && $stable(elapsed)))
    else $error("stalled response changed");

  // Time, month and elapsed time in range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (hour < 5'(HoursPerDay) && minute < 6'(MinsPerHour) &&
                   second < 6'(SecsPerMin) && month >= MonthJan &&
                   month <= 4'(MonthsPerYear) && elapsed < DayLength))
    else $error("response time or date out of range");

  // A rejected set carries no query result.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rejected) |-> (!passed && elapsed == '0))
    else $error("rejected item carries a query result");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind seconds_of_day_calendar_clock_unit sodcc_checker u_sodcc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .hour      (rsp.data.hour),
  .minute    (rsp.data.minute),
  .second    (rsp.data.second),
  .month     (rsp.data.month),
  .elapsed   (rsp.data.elapsed),
  .passed    (rsp.data.passed),
  .rejected  (rsp.data.rejected)
);
